[hdl/ryc_pkg.sv]
// ----------------------------------------------------------------------------
// ryc_pkg - shared types and constants for the RGB to YCbCr 4:2:0 converter
// Fixed-point coefficients per colour matrix and range, pipeline control.
// ----------------------------------------------------------------------------
`default_nettype none

package ryc_pkg;

	localparam int F      = 16;             // coefficient fraction bits
	localparam int PIX_W  = 8;
	localparam int SUM_W  = PIX_W + 2;      // sum of four samples
	localparam int COEF_W = F + 1;          // holds 1.0
	localparam int CG_W   = F;              // chroma gains stay below 1.0
	localparam int LSUM_W = F + PIX_W;      // weighted luma sum
	localparam int LT_W   = 2 * F + 9;      // scaled luma plus offset
	localparam int CY_W   = F + SUM_W;      // weighted block sum
	localparam int D_W    = F + SUM_W + 1;  // signed colour difference
	localparam int CP_W   = D_W + CG_W + 1; // difference times gain
	localparam int CT_W   = CP_W + 1;       // plus centre

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam longint ONE = longint'(1) << F;

	localparam longint KR_601  = (2990 * ONE + 5000) / 10000;
	localparam longint KB_601  = (1140 * ONE + 5000) / 10000;
	localparam longint KR_709  = (2126 * ONE + 5000) / 10000;
	localparam longint KB_709  = (722 * ONE + 5000) / 10000;
	localparam longint KR_2020 = (2627 * ONE + 5000) / 10000;
	localparam longint KB_2020 = (593 * ONE + 5000) / 10000;

	localparam longint LG_LIM  = (219 * ONE + 255 / 2) / 255;

	// full range: 1 / (2(1-k))
	localparam longint DF_B601  = 2 * (10000 - 1140);
	localparam longint DF_R601  = 2 * (10000 - 2990);
	localparam longint DF_B709  = 2 * (10000 - 722);
	localparam longint DF_R709  = 2 * (10000 - 2126);
	localparam longint DF_B2020 = 2 * (10000 - 593);
	localparam longint DF_R2020 = 2 * (10000 - 2627);
	localparam longint CGF_B601  = (10000 * ONE + DF_B601 / 2) / DF_B601;
	localparam longint CGF_R601  = (10000 * ONE + DF_R601 / 2) / DF_R601;
	localparam longint CGF_B709  = (10000 * ONE + DF_B709 / 2) / DF_B709;
	localparam longint CGF_R709  = (10000 * ONE + DF_R709 / 2) / DF_R709;
	localparam longint CGF_B2020 = (10000 * ONE + DF_B2020 / 2) / DF_B2020;
	localparam longint CGF_R2020 = (10000 * ONE + DF_R2020 / 2) / DF_R2020;

	// limited range: (224/255) / (2(1-k))
	localparam longint NL       = 224 * 10000 * ONE;
	localparam longint DL_B601  = 510 * (10000 - 1140);
	localparam longint DL_R601  = 510 * (10000 - 2990);
	localparam longint DL_B709  = 510 * (10000 - 722);
	localparam longint DL_R709  = 510 * (10000 - 2126);
	localparam longint DL_B2020 = 510 * (10000 - 593);
	localparam longint DL_R2020 = 510 * (10000 - 2627);
	localparam longint CGL_B601  = (NL + DL_B601 / 2) / DL_B601;
	localparam longint CGL_R601  = (NL + DL_R601 / 2) / DL_R601;
	localparam longint CGL_B709  = (NL + DL_B709 / 2) / DL_B709;
	localparam longint CGL_R709  = (NL + DL_R709 / 2) / DL_R709;
	localparam longint CGL_B2020 = (NL + DL_B2020 / 2) / DL_B2020;
	localparam longint CGL_R2020 = (NL + DL_R2020 / 2) / DL_R2020;

	typedef enum logic [1:0] {
		MAT_BT601  = 2'd0,
		MAT_BT709  = 2'd1,
		MAT_BT2020 = 2'd2
	} matrix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLOR_MATRIX = 2'd0,
		REG_FULL_RANGE   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		logic [COEF_W-1:0] kr;
		logic [COEF_W-1:0] kg;
		logic [COEF_W-1:0] kb;
		logic [COEF_W-1:0] lg;
		logic [CG_W-1:0]   cgb;
		logic [CG_W-1:0]   cgr;
		logic              full;
	} coef_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	function automatic coef_t coef_sel(input logic [1:0] matrix, input logic full);
		coef_t c;
		longint kr, kb, cgbf, cgrf, cgbl, cgrl;
		case (matrix)
			MAT_BT709: begin
				kr = KR_709; kb = KB_709;
				cgbf = CGF_B709; cgrf = CGF_R709; cgbl = CGL_B709; cgrl = CGL_R709;
			end
			MAT_BT2020: begin
				kr = KR_2020; kb = KB_2020;
				cgbf = CGF_B2020; cgrf = CGF_R2020; cgbl = CGL_B2020; cgrl = CGL_R2020;
			end
			default: begin
				kr = KR_601; kb = KB_601;
				cgbf = CGF_B601; cgrf = CGF_R601; cgbl = CGL_B601; cgrl = CGL_R601;
			end
		endcase
		c.kr   = COEF_W'(kr);
		c.kb   = COEF_W'(kb);
		c.kg   = COEF_W'(ONE - kr - kb);
		c.lg   = full ? COEF_W'(ONE) : COEF_W'(LG_LIM);
		c.cgb  = full ? CG_W'(cgbf) : CG_W'(cgbl);
		c.cgr  = full ? CG_W'(cgrf) : CG_W'(cgrl);
		c.full = full;
		return c;
	endfunction

endpackage

`default_nettype wire

[hdl/ryc_luma_lane.sv]
// ----------------------------------------------------------------------------
// ryc_luma_lane - luma for one pixel of the block
// Weighted sum, range scale and offset, clamp and round; four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ryc_luma_lane (
	input  wire logic                 clk,
	input  wire ryc_pkg::pipe_en_t    en,
	input  wire ryc_pkg::coef_t       coef,
	input  wire ryc_pkg::rgb_t        pix,
	output logic [ryc_pkg::PIX_W-1:0] luma
);
	import ryc_pkg::*;

	localparam logic [LT_W-1:0] OFS  = LT_W'(16) << (2 * F);
	localparam logic [LT_W-1:0] TOP  = LT_W'(255) << (2 * F);
	localparam logic [LT_W-1:0] HALF = LT_W'(1) << (2 * F - 1);

	logic [COEF_W+PIX_W-1:0] pr, pg, pb;
	logic [LSUM_W-1:0]       wsum_s1;
	logic [LT_W-1:0]         prod;
	logic [LT_W-1:0]         t_s2;
	logic [LT_W-1:0]         rnd;
	logic [PIX_W-1:0]        y_s3, y_s4;

	assign pr   = coef.kr * pix.red;
	assign pg   = coef.kg * pix.green;
	assign pb   = coef.kb * pix.blue;
	assign prod = wsum_s1 * coef.lg;
	assign rnd  = (t_s2 + HALF) >> (2 * F);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			wsum_s1 <= LSUM_W'(pr + pg + pb);
		end
		if (en.s2) begin
			t_s2 <= prod + (coef.full ? '0 : OFS);
		end
		if (en.s3) begin
			y_s3 <= (t_s2 > TOP) ? PIX_W'(255) : rnd[PIX_W-1:0];
		end
		if (en.s4) begin
			y_s4 <= y_s3;
		end
	end

	assign luma = y_s4;

endmodule

`default_nettype wire

[hdl/ryc_chroma_unit.sv]
// ----------------------------------------------------------------------------
// ryc_chroma_unit - Cb and Cr from the block-average colour
// Block sums, weighted sum, colour difference times gain, clamp and round.
// ----------------------------------------------------------------------------
`default_nettype none

module ryc_chroma_unit (
	input  wire logic                 clk,
	input  wire ryc_pkg::pipe_en_t    en,
	input  wire ryc_pkg::coef_t       coef,
	input  wire ryc_pkg::rgb_t [3:0]  px,
	output logic [ryc_pkg::PIX_W-1:0] cb,
	output logic [ryc_pkg::PIX_W-1:0] cr
);
	import ryc_pkg::*;

	localparam logic signed [CT_W-1:0] CTR_LIM  = CT_W'(256) <<< (2 * F + 1);
	localparam logic signed [CT_W-1:0] CTR_FULL = CT_W'(255) <<< (2 * F + 1);
	localparam logic signed [CT_W-1:0] TOP      = CT_W'(255) <<< (2 * F + 2);
	localparam logic signed [CT_W-1:0] HALF     = CT_W'(1) <<< (2 * F + 1);

	logic [SUM_W-1:0]        sr_s1, sg_s1, sb_s1;
	logic [SUM_W-1:0]        sr_s2, sb_s2;
	logic [COEF_W+SUM_W-1:0] yr, yg, yb;
	logic [CY_W-1:0]         ys_s2;
	logic signed [D_W-1:0]   db, dr;
	logic signed [CP_W-1:0]  pcb, pcr;
	logic signed [CT_W-1:0]  ctr;
	logic signed [CT_W-1:0]  tb_s3, tr_s3;
	logic signed [CT_W-1:0]  rb, rr;
	logic [PIX_W-1:0]        cb_s4, cr_s4;

	assign yr = coef.kr * sr_s1;
	assign yg = coef.kg * sg_s1;
	assign yb = coef.kb * sb_s1;

	assign db  = $signed(D_W'({sb_s2, {F{1'b0}}})) - $signed(D_W'(ys_s2));
	assign dr  = $signed(D_W'({sr_s2, {F{1'b0}}})) - $signed(D_W'(ys_s2));
	assign pcb = db * $signed({1'b0, coef.cgb});
	assign pcr = dr * $signed({1'b0, coef.cgr});
	assign ctr = coef.full ? CTR_FULL : CTR_LIM;

	assign rb = (tb_s3 + HALF) >>> (2 * F + 2);
	assign rr = (tr_s3 + HALF) >>> (2 * F + 2);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sr_s1 <= SUM_W'(px[0].red)   + SUM_W'(px[1].red)
			       + SUM_W'(px[2].red)   + SUM_W'(px[3].red);
			sg_s1 <= SUM_W'(px[0].green) + SUM_W'(px[1].green)
			       + SUM_W'(px[2].green) + SUM_W'(px[3].green);
			sb_s1 <= SUM_W'(px[0].blue)  + SUM_W'(px[1].blue)
			       + SUM_W'(px[2].blue)  + SUM_W'(px[3].blue);
		end
		if (en.s2) begin
			ys_s2 <= CY_W'(yr + yg + yb);
			sr_s2 <= sr_s1;
			sb_s2 <= sb_s1;
		end
		if (en.s3) begin
			tb_s3 <= ctr + CT_W'(pcb);
			tr_s3 <= ctr + CT_W'(pcr);
		end
		if (en.s4) begin
			cb_s4 <= tb_s3[CT_W-1] ? '0 : (tb_s3 > TOP) ? PIX_W'(255) : rb[PIX_W-1:0];
			cr_s4 <= tr_s3[CT_W-1] ? '0 : (tr_s3 > TOP) ? PIX_W'(255) : rr[PIX_W-1:0];
		end
	end

	assign cb = cb_s4;
	assign cr = cr_s4;

endmodule

`default_nettype wire

[hdl/rgb_to_ycbcr420_block_unit.sv]
// ----------------------------------------------------------------------------
// rgb_to_ycbcr420_block_unit - 2x2 RGB block to YCbCr 4:2:0
// Four luma lanes and one chroma unit in parallel, merged into one beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid / s_tready | s_tdata: 4 pixels x {R,G,B}, 96 bits
//  m_*     | out | m_tvalid / m_tready | m_tdata: 4 luma, Cb, Cr, 48 bits
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One block per cycle while m_tready is high; blocks pass through the four-stage lanes.
//  Each stage has its own valid bit and loads when empty or when the next
//  stage moves, so bubbles close up while m_tready is low.
//  Reset clears the stage valids and selects BT.601 limited range.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_ycbcr420_block_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// red/green/blue top_left, top_right, bottom_left, bottom_right
	input  wire logic [12*ryc_pkg::PIX_W-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// luma tl, tr, bl, br, chroma_blue, chroma_red
	output logic [6*ryc_pkg::PIX_W-1:0]          m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ryc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ryc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ryc_pkg::*;

	logic [1:0]         matrix_q;
	logic               full_q;
	coef_t              coef;
	rgb_t [3:0]         px;
	pipe_en_t           en;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [PIX_W-1:0]   luma [4];
	logic [PIX_W-1:0]   cb, cr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= MAT_BT601;
			full_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLOR_MATRIX: matrix_q <= cfg_data[1:0];
				REG_FULL_RANGE:   full_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign coef = coef_sel(matrix_q, full_q);
	assign px   = s_tdata;

	assign en.s4 = !v_s4 || m_tready;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_luma
		ryc_luma_lane u_lane (
			.clk  (clk),
			.en   (en),
			.coef (coef),
			.pix  (px[i]),
			.luma (luma[i])
		);
	end

	ryc_chroma_unit u_chroma (
		.clk  (clk),
		.en   (en),
		.coef (coef),
		.px   (px),
		.cb   (cb),
		.cr   (cr)
	);

	assign s_tready = en.s1;
	assign m_tvalid = v_s4;
	assign m_tdata  = {cr, cb, luma[3], luma[2], luma[1], luma[0]};

endmodule

`default_nettype wire

[sim/ycc_block_checker.sv]
// ----------------------------------------------------------------------------
// ycc_block_checker - scoreboard for the 2x2 RGB to YCbCr 4:2:0 converter
// Tracks the register writes and predicts each accepted block in fixed point
// (luma, then Cb and Cr from the block sums). It compares every output beat
// field by field with the oldest prediction and counts the mismatches.
// ----------------------------------------------------------------------------

module ycc_block_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [12*ryc_pkg::PIX_W-1:0]   s_tdata,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [6*ryc_pkg::PIX_W-1:0]    m_tdata,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [ryc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ryc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  mismatches,
	output int                                  in_flight
);

	timeunit 1ns;
	timeprecision 1ps;

	import ryc_pkg::*;

	localparam int FRAC = F;

	logic [6*PIX_W-1:0] ycc_expected_q[$];
	logic [1:0]         matrix_sel;
	logic               full_sel;
	int                 errors = 0;
	string              field_name[6] = '{"luma_top_left", "luma_top_right",
		"luma_bottom_left", "luma_bottom_right", "chroma_blue", "chroma_red"};

	function automatic longint div_half_up(input longint num, input longint den);
		return (num + den / 2) / den;
	endfunction

	function automatic logic [7:0] clip_round(input longint t, input int shift);
		longint top;
		top = longint'(255) << shift;
		if (t < 0)
			t = 0;
		if (t > top)
			t = top;
		return 8'((t + (longint'(1) << (shift - 1))) >> shift);
	endfunction

	function automatic logic [6*PIX_W-1:0] ycc_from_block(input logic [12*PIX_W-1:0] blk,
			input logic [1:0] mat, input logic full);
		longint one, kr_dec, kb_dec, kr, kb, kg, lg, cgb, cgr, luma_off, centre;
		longint sr, sg, sb, r, g, b, ys;
		logic [6*PIX_W-1:0] res;
		one = longint'(1) << FRAC;
		case (mat)
			MAT_BT709: begin
				kr_dec = 2126;
				kb_dec = 722;
			end
			MAT_BT2020: begin
				kr_dec = 2627;
				kb_dec = 593;
			end
			default: begin
				kr_dec = 2990;
				kb_dec = 1140;
			end
		endcase
		kr = div_half_up(kr_dec * one, 10000);
		kb = div_half_up(kb_dec * one, 10000);
		kg = one - kr - kb;
		if (full) begin
			lg = one;
			luma_off = 0;
			centre = 255;	// half units
			cgb = div_half_up(10000 * one, 2 * (10000 - kb_dec));
			cgr = div_half_up(10000 * one, 2 * (10000 - kr_dec));
		end else begin
			lg = div_half_up(219 * one, 255);
			luma_off = 16;
			centre = 256;
			cgb = div_half_up(224 * 10000 * one, 510 * (10000 - kb_dec));
			cgr = div_half_up(224 * 10000 * one, 510 * (10000 - kr_dec));
		end
		sr = 0;
		sg = 0;
		sb = 0;
		res = '0;
		for (int i = 0; i < 4; i++) begin
			r = blk[24*i +: 8];
			g = blk[24*i+8 +: 8];
			b = blk[24*i+16 +: 8];
			sr += r;
			sg += g;
			sb += b;
			res[8*i +: 8] = clip_round((luma_off << (2 * FRAC)) + (kr * r + kg * g + kb * b) * lg,
				2 * FRAC);
		end
		ys = kr * sr + kg * sg + kb * sb;
		res[39:32] = clip_round((centre << (2 * FRAC + 1)) + (sb * one - ys) * cgb, 2 * FRAC + 2);
		res[47:40] = clip_round((centre << (2 * FRAC + 1)) + (sr * one - ys) * cgr, 2 * FRAC + 2);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < 40)
			$display("%0t ns: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [6*PIX_W-1:0] want;
		if (!arst_n) begin
			matrix_sel = MAT_BT601;
			full_sel = 1'b0;
			ycc_expected_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (ycc_expected_q.size() == 0) begin
					report_mismatch($sformatf("output beat %h with nothing expected", m_tdata));
				end else begin
					want = ycc_expected_q.pop_front();
					for (int i = 0; i < 6; i++)
						if (m_tdata[8*i +: 8] !== want[8*i +: 8])
							report_mismatch($sformatf("%s got %0d expected %0d",
								field_name[i], m_tdata[8*i +: 8], want[8*i +: 8]));
				end
			end
			if (s_tvalid && s_tready)
				ycc_expected_q.push_back(ycc_from_block(s_tdata, matrix_sel, full_sel));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COLOR_MATRIX: matrix_sel = cfg_data;
					REG_FULL_RANGE:   full_sel = cfg_data[0];
					default: ;
				endcase
			end
		end
		mismatches <= errors;
		in_flight <= ycc_expected_q.size();
	end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for rgb_to_ycbcr420_block_unit
// Directed blocks at reset settings, then random blocks across every matrix
// and range, under varied source gaps and sink stalls with one long back
// pressure stretch. Checking is done by ycc_block_checker.
// ----------------------------------------------------------------------------

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import ryc_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int BLOCKS_PER_SET  = 82;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [12*PIX_W-1:0]    s_tdata;	// R,G,B of tl, tr, bl, br
	logic                   m_tvalid;
	logic                   m_tready;
	logic [6*PIX_W-1:0]     m_tdata;	// Y tl, tr, bl, br, Cb, Cr
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int   mismatches;
	int   in_flight;
	int   cycles = 0;
	int   src_gap_pct = 0;
	int   sink_stall_pct = 0;
	logic hold_off = 1'b0;
	logic pressure_req = 1'b0;

	always #6 clk = ~clk;

	rgb_to_ycbcr420_block_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ycc_block_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[rgb_to_ycbcr420_block_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
	end

	// long sink hold-off while the source keeps offering blocks
	initial begin
		wait (pressure_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [12*PIX_W-1:0] flat_block(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {4{b, g, r}};
	endfunction

	function automatic logic [12*PIX_W-1:0] random_block();
		logic [12*PIX_W-1:0] blk;
		int mode;
		mode = $urandom_range(9);
		if (mode == 0)
			return flat_block($urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
				$urandom_range(1) ? 8'hFF : 8'h00);
		for (int i = 0; i < 12; i++) begin
			if (mode < 4)
				blk[8*i +: 8] = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) :
					($urandom_range(1) ? 8'hFF : 8'h00);
			else
				blk[8*i +: 8] = 8'($urandom_range(255));
		end
		return blk;
	endfunction

	task automatic send_block(input logic [12*PIX_W-1:0] blk);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= blk;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (in_flight != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [1:0] mat;
		logic       rng;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks, reset settings
		send_block(flat_block(8'h00, 8'h00, 8'h00));
		send_block(flat_block(8'hFF, 8'hFF, 8'hFF));
		send_block(flat_block(8'hFF, 8'h00, 8'h00));
		send_block(flat_block(8'h00, 8'hFF, 8'h00));
		send_block(flat_block(8'h00, 8'h00, 8'hFF));
		send_block(flat_block(8'h00, 8'hFF, 8'hFF));
		send_block(flat_block(8'hFF, 8'h00, 8'hFF));
		send_block(flat_block(8'hFF, 8'hFF, 8'h00));
		send_block({12{8'hAA}});
		send_block({12{8'h55}});
		send_block({72'h0, 24'hFFFFFF});
		send_block({24'hFFFFFF, 72'h0});
		send_block({24'hFF0000, 24'h0000FF, 24'h0000FF, 24'hFF0000});
		send_block(96'h1020_4080_FEFD_FBF7_EFDF_BF7F);
		send_block(96'h01FE_7F80_FF00_8001_7FFE_00FF);
		send_block(flat_block(8'h80, 8'h80, 8'h80));

		for (int set_no = 0; set_no < 8; set_no++) begin
			drain();
			mat = 2'((set_no + set_no / 4) % 4);
			rng = set_no >= 4;
			cfg_write(REG_FULL_RANGE, {1'($urandom_range(1)), rng});
			cfg_write(REG_COLOR_MATRIX, mat);
			cfg_write(REG_SPARE + 2'(set_no % 2), 2'($urandom_range(3)));
			case (set_no % 4)
				0: begin
					src_gap_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_gap_pct = 51;
					sink_stall_pct = 0;
				end
				2: begin
					src_gap_pct = 0;
					sink_stall_pct = 51;
				end
				default: begin
					src_gap_pct = 16;
					sink_stall_pct = 16;
				end
			endcase
			if (set_no == 0)
				pressure_req = 1'b1;
			repeat (BLOCKS_PER_SET) send_block(random_block());
		end
		drain();

		if (mismatches == 0)
			$display("[rgb_to_ycbcr420_block_unit] OK");
		else
			$display("[rgb_to_ycbcr420_block_unit] ERROR");
		$finish;
	end

endmodule
